@@ hdl/arq_pkg.sv @@
// Shared types and codes for the acknowledged retransmit queue.
`timescale 1ns / 1ps
package arq_pkg;

  // Operation codes of an input item
  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_ACK  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_SENT       = 3'd0;
  localparam logic [2:0] KIND_SEND_FAIL  = 3'd1;
  localparam logic [2:0] KIND_QUEUE_FULL = 3'd2;
  localparam logic [2:0] KIND_ACKED      = 3'd3;
  localparam logic [2:0] KIND_ACK_NOMATCH = 3'd4;
  localparam logic [2:0] KIND_RETRANSMIT = 3'd5;
  localparam logic [2:0] KIND_GAVE_UP    = 3'd6;
  localparam logic [2:0] KIND_TICK_DONE  = 3'd7;

  // Configuration register indexes
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_RETRIES = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [3:0]  RETRIES_RESET = 4'd3;

  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] event_word;
    logic [31:0] sent_at;
    logic [3:0]  retries;
  } entry_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] seq_out;
    logic [31:0] event_out;
    logic [3:0]  attempt;
    logic [31:0] rtt_ms;
    logic        last;
  } result_t;

endpackage

@@ hdl/ack_retransmit_queue_unit.sv @@
// Top level of the acknowledged retransmit queue: sequencer, config and result register.
`timescale 1ns / 1ps
//
//  channel   | ports                                         | transfer
//  ----------+-----------------------------------------------+---------------------------
//  command   | start, busy, func_i, event_word_i,            | start & !busy
//            | ack_seq_i, now_ms_i, link_up_i, send_ok_i     |
//  result    | result_valid_o, kind_o, seq_out_o, ...        | result_valid_o (one cycle)
//  config    | cfg_we_i, cfg_idx_i, cfg_data_i               | cfg_we_i
//
//  Steps: send uses the send state alone; ack reads the head entry, retires stale
//  entries in turn, then acks or reports no match; tick reads the head and checks each
//  queued entry in turn. Steps run one at a time because the entry memory has a single
//  read port and one shared subtractor serves the ack distance, round-trip time and
//  elapsed-time checks. Results leave through a register in the cycle after the step
//  that forms them; a tick gives one result per expired entry, then its tick-done
//  result. Reset clears the sequencer, head, count, next sequence and config; the
//  entry memory is not cleared, only entries inside the queue are ever read. func 3
//  is dropped. The receiver cannot stall: results are shown for exactly one cycle.
//
module ack_retransmit_queue_unit
  import arq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [31:0] event_word_i,
  input  logic [15:0] ack_seq_i,
  input  logic [31:0] now_ms_i,
  input  logic        link_up_i,
  input  logic        send_ok_i,
  // config
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // result
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [15:0] seq_out_o,
  output logic [31:0] event_out_o,
  output logic [3:0]  attempt_o,
  output logic [31:0] rtt_ms_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] pending_count_o,
  output logic        last_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // sequencer state codes
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SEND    = 4'd1;
  localparam logic [3:0] ST_ACK_RD  = 4'd2;
  localparam logic [3:0] ST_ACK_EV  = 4'd3;
  localparam logic [3:0] ST_ACK_RTT = 4'd4;
  localparam logic [3:0] ST_ACK_NOM = 4'd5;
  localparam logic [3:0] ST_TICK_RD = 4'd6;
  localparam logic [3:0] ST_TICK_EV = 4'd7;
  localparam logic [3:0] ST_TICK_END = 4'd8;

  logic [3:0]       state_q, state_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      nseq_q, nseq_d;
  logic [15:0]      tmo_q;
  logic [3:0]       maxr_q;
  logic [CNT_W-1:0] idx_q, idx_d;    // entry under inspection in a tick
  logic [CNT_W-1:0] wr_q, wr_d;      // compaction write position in a tick
  logic             vld_q, vld_d;
  result_t          res_q, res_d;
  logic [CNT_W-1:0] pend_q, pend_d;

  // latched command
  logic [31:0] ev_q;
  logic [15:0] ack_q;
  logic [31:0] now_q;
  logic        link_q;
  logic        ok_q;

  // memory port
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  entry_t           wr_data;

  // shared unit
  logic [31:0] sub_a, sub_b, sub_lim, sub_diff;
  logic        sub_ge;

  logic accept;
  assign accept = start & ~busy;
  assign busy   = (state_q != ST_IDLE);

  // circular index: head + k, known to stay below twice the depth
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] head,
                                            input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(k);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  arq_store #(
    .DEPTH (QUEUE_DEPTH),
    .PTR_W (PTR_W)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  arq_sub u_sub (
    .a_i     (sub_a),
    .b_i     (sub_b),
    .limit_i (sub_lim),
    .diff_o  (sub_diff),
    .ge_o    (sub_ge)
  );

  logic [15:0]      ack_dist;
  logic [CNT_W-1:0] pend_rt;
  logic [3:0]       att_inc;
  entry_t           new_entry;
  entry_t           kept_entry;

  assign ack_dist = sub_diff[15:0];
  // entries left mid-walk: count minus entries dropped so far
  assign pend_rt  = cnt_q - idx_q + wr_q;
  assign att_inc  = rd_data.retries + 4'd1;

  always_comb begin
    new_entry.seq        = nseq_q;
    new_entry.event_word = ev_q;
    new_entry.sent_at    = now_q;
    new_entry.retries    = 4'd0;
    kept_entry.seq        = rd_data.seq;
    kept_entry.event_word = rd_data.event_word;
    kept_entry.sent_at    = sub_ge ? now_q : rd_data.sent_at;
    kept_entry.retries    = sub_ge ? att_inc : rd_data.retries;
  end

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    nseq_d  = nseq_q;
    idx_d   = idx_q;
    wr_d    = wr_q;
    vld_d   = 1'b0;
    res_d   = res_q;
    pend_d  = pend_q;
    rd_en   = 1'b0;
    rd_addr = head_q;
    wr_en   = 1'b0;
    wr_addr = slot(head_q, wr_q);
    wr_data = kept_entry;
    sub_a   = now_q;
    sub_b   = rd_data.sent_at;
    sub_lim = {16'd0, tmo_q};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_SEND: state_d = ST_SEND;
            FUNC_ACK:  state_d = ST_ACK_RD;
            FUNC_TICK: state_d = ST_TICK_RD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end

      ST_SEND: begin
        vld_d         = 1'b1;
        res_d         = '0;
        res_d.last    = 1'b1;
        pend_d        = cnt_q;
        state_d       = ST_IDLE;
        if (!link_q) begin
          res_d.kind = KIND_SEND_FAIL;
        end else if (cnt_q >= CNT_W'(QUEUE_DEPTH)) begin
          res_d.kind = KIND_QUEUE_FULL;
        end else begin
          nseq_d        = nseq_q + 16'd1;
          res_d.seq_out = nseq_q;
          if (!ok_q) begin
            res_d.kind = KIND_SEND_FAIL;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = slot(head_q, cnt_q);
            wr_data    = new_entry;
            cnt_d      = cnt_q + CNT_W'(1);
            pend_d     = cnt_q + CNT_W'(1);
            res_d.kind = KIND_SENT;
          end
        end
      end

      ST_ACK_RD: begin
        if (cnt_q == '0) begin
          state_d = ST_ACK_NOM;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q;
          state_d = ST_ACK_EV;
        end
      end

      ST_ACK_EV: begin
        sub_a = {16'd0, ack_q};
        sub_b = {16'd0, rd_data.seq};
        if (ack_dist == 16'd0) begin
          state_d = ST_ACK_RTT;
        end else if (!ack_dist[15]) begin
          // stale head: retire silently and look at the next one
          head_d = slot(head_q, CNT_W'(1));
          cnt_d  = cnt_q - CNT_W'(1);
          if (cnt_q > CNT_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = slot(head_q, CNT_W'(1));
          end else begin
            state_d = ST_ACK_NOM;
          end
        end else begin
          state_d = ST_ACK_NOM;
        end
      end

      ST_ACK_RTT: begin
        head_d        = slot(head_q, CNT_W'(1));
        cnt_d         = cnt_q - CNT_W'(1);
        vld_d         = 1'b1;
        res_d         = '0;
        res_d.kind    = KIND_ACKED;
        res_d.seq_out = ack_q;
        res_d.rtt_ms  = sub_diff;
        res_d.last    = 1'b1;
        pend_d        = cnt_q - CNT_W'(1);
        state_d       = ST_IDLE;
      end

      ST_ACK_NOM: begin
        vld_d         = 1'b1;
        res_d         = '0;
        res_d.kind    = KIND_ACK_NOMATCH;
        res_d.seq_out = ack_q;
        res_d.last    = 1'b1;
        pend_d        = cnt_q;
        state_d       = ST_IDLE;
      end

      ST_TICK_RD: begin
        idx_d = '0;
        wr_d  = '0;
        if (cnt_q == '0) begin
          state_d = ST_TICK_END;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q;
          state_d = ST_TICK_EV;
        end
      end

      ST_TICK_EV: begin
        // sub_ge: elapsed time reached the timeout
        if (sub_ge && (rd_data.retries >= maxr_q)) begin
          vld_d           = 1'b1;
          res_d           = '0;
          res_d.kind      = KIND_GAVE_UP;
          res_d.seq_out   = rd_data.seq;
          res_d.event_out = rd_data.event_word;
          res_d.attempt   = rd_data.retries;
          pend_d          = pend_rt - CNT_W'(1);
        end else begin
          wr_en = 1'b1;
          wr_d  = wr_q + CNT_W'(1);
          if (sub_ge) begin
            vld_d           = 1'b1;
            res_d           = '0;
            res_d.kind      = KIND_RETRANSMIT;
            res_d.seq_out   = rd_data.seq;
            res_d.event_out = rd_data.event_word;
            res_d.attempt   = att_inc;
            pend_d          = pend_rt;
          end
        end
        if ((idx_q + CNT_W'(1)) < cnt_q) begin
          rd_en   = 1'b1;
          rd_addr = slot(head_q, idx_q + CNT_W'(1));
          idx_d   = idx_q + CNT_W'(1);
        end else begin
          state_d = ST_TICK_END;
        end
      end

      ST_TICK_END: begin
        cnt_d      = wr_q;
        vld_d      = 1'b1;
        res_d      = '0;
        res_d.kind = KIND_TICK_DONE;
        res_d.last = 1'b1;
        pend_d     = wr_q;
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      nseq_q  <= '0;
      idx_q   <= '0;
      wr_q    <= '0;
      vld_q   <= 1'b0;
      tmo_q   <= TIMEOUT_RESET;
      maxr_q  <= RETRIES_RESET;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      nseq_q  <= nseq_d;
      idx_q   <= idx_d;
      wr_q    <= wr_d;
      vld_q   <= vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TIMEOUT: tmo_q  <= cfg_data_i;
          REG_RETRIES: maxr_q <= cfg_data_i[3:0];
          default:     tmo_q  <= tmo_q;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    pend_q <= pend_d;
    if (accept) begin
      ev_q   <= event_word_i;
      ack_q  <= ack_seq_i;
      now_q  <= now_ms_i;
      link_q <= link_up_i;
      ok_q   <= send_ok_i;
    end
  end

  assign result_valid_o  = vld_q;
  assign kind_o          = res_q.kind;
  assign seq_out_o       = res_q.seq_out;
  assign event_out_o     = res_q.event_out;
  assign attempt_o       = res_q.attempt;
  assign rtt_ms_o        = res_q.rtt_ms;
  assign pending_count_o = pend_q;
  assign last_o          = res_q.last;

  // queue never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  // compaction write position never passes the read position
  a_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TICK_EV) |-> (wr_q <= idx_q))
    else $error("tick write position ahead of read position");

  // ack handling never writes the entry memory
  a_ack_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACK_EV || state_q == ST_ACK_RTT || state_q == ST_ACK_NOM) |-> !wr_en)
    else $error("memory write during ack");

  // a tick-done result is always the final result of its item
  a_tick_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == KIND_TICK_DONE) |-> last_o)
    else $error("tick done without last");

  // the last result of an item leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_d && res_d.last) |=> (state_q == ST_IDLE))
    else $error("final result while sequencer still busy");

endmodule

@@ hdl/arq_sub.sv @@
// Shared 32-bit subtract and compare unit used by the ack and tick steps of the sequencer.
`timescale 1ns / 1ps
module arq_sub
  import arq_pkg::*;
(
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] limit_i,
  output logic [31:0] diff_o,
  output logic        ge_o
);

  assign diff_o = a_i - b_i;
  assign ge_o   = (diff_o >= limit_i);

endmodule

@@ hdl/arq_store.sv @@
// Entry memory of the queue: one write port, one registered read port.
`timescale 1ns / 1ps
module arq_store
  import arq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int PTR_W = 4
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [PTR_W-1:0] rd_addr_i,
  output entry_t           rd_data_o,
  input  logic             wr_en_i,
  input  logic [PTR_W-1:0] wr_addr_i,
  input  entry_t           wr_data_i
);

  entry_t mem_q [DEPTH];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule
